// ===== src/dao_pkg.sv =====
// Shared types and constants for the depth ambient occlusion block.
// Holds the queue item format, the configuration bundle and the code names.
// No dependencies.
package dao_pkg;

  // Widths that cover the whole legal range of the frame and kernel limits.
  localparam int DIM_W   = 13;  // effective frame width or height, up to 4096
  localparam int NCNT_W  = 9;   // effective sample count, up to 256
  localparam int CRD_W   = 9;   // sample coordinate, at most 255 + 127
  localparam int DEPTH_W = 16;
  localparam int AO_W    = 16;
  localparam int OCC_W   = 7;
  localparam int IDX_W   = 6;
  localparam int OFS_W   = 8;
  localparam int POS_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int QUEUE_DEPTH = 4;

  // Input function codes.
  localparam logic [1:0] FUNC_WR_OFS = 2'd0;
  localparam logic [1:0] FUNC_WR_DEP = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH        = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT       = 2'd3;

  typedef enum logic [1:0] {
    OP_WR_OFS,
    OP_WR_DEP,
    OP_QUERY
  } op_t;

  // One classified beat as it travels from the front end to the back end.
  typedef struct packed {
    op_t                      op;
    logic [IDX_W-1:0]         idx;
    logic signed [OFS_W-1:0]  dx;
    logic signed [OFS_W-1:0]  dy;
    logic [POS_W-1:0]         x;
    logic [POS_W-1:0]         y;
    logic [DEPTH_W-1:0]       depth;
  } item_t;

  // Configuration after range limiting.
  typedef struct packed {
    logic [NCNT_W-1:0]  n;
    logic [DEPTH_W-1:0] radius;
    logic [DIM_W-1:0]   w;
    logic [DIM_W-1:0]   h;
  } cfg_t;

endpackage

// ===== src/dao_front.sv =====
// Front end: classifies input beats, drops the ones that do nothing and
// clamps query centres into the frame. Depends on dao_pkg.
module dao_front #(
  parameter int MAX_SAMPLES_P = 64
) (
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_func,
  input  logic [dao_pkg::IDX_W-1:0]   in_entry_index,
  input  logic signed [7:0]           in_offset_dx,
  input  logic signed [7:0]           in_offset_dy,
  input  logic [dao_pkg::POS_W-1:0]   in_pos_x,
  input  logic [dao_pkg::POS_W-1:0]   in_pos_y,
  input  logic [15:0]                 in_depth_value,
  input  dao_pkg::cfg_t               cfg,
  input  logic                        q_full,
  output logic                        q_push,
  output dao_pkg::item_t              q_item
);
  import dao_pkg::*;

  logic keep;
  logic x_in, y_in;

  assign x_in = 32'(in_pos_x) < 32'(cfg.w);
  assign y_in = 32'(in_pos_y) < 32'(cfg.h);

  always_comb begin
    q_item.op    = OP_QUERY;
    q_item.idx   = in_entry_index;
    q_item.dx    = in_offset_dx;
    q_item.dy    = in_offset_dy;
    q_item.x     = in_pos_x;
    q_item.y     = in_pos_y;
    q_item.depth = in_depth_value;
    keep         = 1'b0;
    case (in_func)
      FUNC_WR_OFS: begin
        q_item.op = OP_WR_OFS;
        keep      = 32'(in_entry_index) < MAX_SAMPLES_P;
      end
      FUNC_WR_DEP: begin
        q_item.op = OP_WR_DEP;
        keep      = x_in && y_in;
      end
      FUNC_QUERY: begin
        // The centre is pulled into the frame before any sample is taken.
        q_item.op = OP_QUERY;
        keep      = 1'b1;
        if (!x_in) q_item.x = POS_W'(cfg.w - 1'b1);
        if (!y_in) q_item.y = POS_W'(cfg.h - 1'b1);
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && keep;

endmodule

// ===== src/dao_queue.sv =====
// Short queue of classified beats between the front end and the back end.
// Depends on dao_pkg for the item format.
module dao_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dao_pkg::item_t push_item,
  input  logic           pop,
  output dao_pkg::item_t head,
  output logic           empty,
  output logic           full
);
  import dao_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t          slot_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  fill_r, fill_nxt;
  logic           do_push, do_pop;

  assign empty   = (fill_r == '0);
  assign full    = (fill_r == CW'(DEPTH));
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) fill_nxt = fill_r + 1'b1;
    else if (do_pop && !do_push) fill_nxt = fill_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_item;
  end

endmodule

// ===== src/dao_div.sv =====
// Restoring divider for the exposure level: floor(num * 2^16 / den).
// One quotient bit per cycle. Depends on dao_pkg.
module dao_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [dao_pkg::NCNT_W-1:0]  num,
  input  logic [dao_pkg::NCNT_W-1:0]  den,
  output logic                        fin,
  output logic [dao_pkg::AO_W-1:0]    quo
);
  import dao_pkg::*;

  localparam int SW = $clog2(AO_W + 1);

  logic [NCNT_W-1:0] rem_r, rem_nxt;
  logic [AO_W-1:0]   quo_r, quo_nxt;
  logic [SW-1:0]     step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              fin_r, fin_nxt;
  logic [NCNT_W:0]   rem2;
  logic              ge;

  // The numerator never exceeds the divisor, so the partial remainder stays
  // within the divisor width. A numerator equal to the divisor gives all ones,
  // which is the saturated level.
  assign rem2 = {rem_r, 1'b0};
  assign ge   = rem2 >= {1'b0, den};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    fin_nxt  = 1'b0;
    if (start) begin
      rem_nxt  = num;
      quo_nxt  = '0;
      step_nxt = SW'(AO_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = ge ? NCNT_W'(rem2 - {1'b0, den}) : rem2[NCNT_W-1:0];
      quo_nxt  = {quo_r[AO_W-2:0], ge};
      step_nxt = step_r - 1'b1;
      if (step_r == SW'(1)) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign fin = fin_r;
  assign quo = quo_r;

endmodule

// ===== src/dao_back.sv =====
// Back end: depth frame, offset tables, the sample pipeline and the result
// register. Depends on dao_pkg and dao_div.
module dao_back #(
  parameter int MAX_SAMPLES_P = 64,
  parameter int MAX_WIDTH     = 256,
  parameter int MAX_HEIGHT    = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dao_pkg::cfg_t               cfg,
  input  dao_pkg::item_t              head,
  input  logic                        q_empty,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [dao_pkg::AO_W-1:0]    out_ao_level,
  output logic [dao_pkg::OCC_W-1:0]   out_occluded_count
);
  import dao_pkg::*;

  localparam int FRAME_N = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW      = $clog2(FRAME_N);
  localparam int IW      = (MAX_SAMPLES_P > 1) ? $clog2(MAX_SAMPLES_P) : 1;
  localparam int MW      = CRD_W + DIM_W + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WDEP,
    S_CEN,
    S_RUN,
    S_DIV,
    S_PUT
  } state_t;

  state_t              state_r, state_nxt;
  item_t               cur_r, cur_nxt;
  logic [DEPTH_W-1:0]  cen_r, cen_nxt;
  logic                first_r, first_nxt;
  logic [NCNT_W-1:0]   iss_r, iss_nxt;
  logic [NCNT_W-1:0]   res_r, res_nxt;
  logic [NCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                v1_r, v1_nxt, v2_r, v2_nxt, v3_r, v3_nxt;
  logic [CRD_W-1:0]    sx_r, sx_nxt, sy_r, sy_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [AO_W-1:0]     out_ao_r, out_ao_nxt;
  logic [OCC_W-1:0]    out_cnt_r, out_cnt_nxt;

  logic [DEPTH_W-1:0]  dep_mem [FRAME_N];
  logic [DEPTH_W-1:0]  dep_rd_r;
  logic                dep_we;
  logic [AW-1:0]       dep_addr;
  logic [CRD_W-1:0]    x_sel, y_sel;
  logic [MW-1:0]       lin_addr;

  logic [OFS_W-1:0]    ofs_x_mem [MAX_SAMPLES_P];
  logic [OFS_W-1:0]    ofs_y_mem [MAX_SAMPLES_P];
  logic [OFS_W-1:0]    ofs_x_rd_r, ofs_y_rd_r;
  logic                ofs_we;
  logic [IW-1:0]       ofs_wr_idx, ofs_rd_idx;

  logic                div_start, div_fin;
  logic [AO_W-1:0]     div_quo;
  logic                occ;

  // Offset added to a centre coordinate, then clamped to 0 .. size-1.
  function automatic logic [CRD_W-1:0] clamp_off(
    input logic [POS_W-1:0]        c,
    input logic signed [OFS_W-1:0] d,
    input logic [DIM_W-1:0]        size
  );
    logic signed [CRD_W:0] sum;
    logic [CRD_W-1:0]      res;
    sum = $signed({2'b00, c}) + (CRD_W+1)'(d);
    if (sum < 0) res = '0;
    else if (DIM_W'(sum[CRD_W-1:0]) >= size) res = CRD_W'(size - 1'b1);
    else res = sum[CRD_W-1:0];
    return res;
  endfunction

  // One shared row-major address unit for writes, the centre and samples.
  assign x_sel    = (state_r == S_RUN) ? sx_r : {1'b0, cur_r.x};
  assign y_sel    = (state_r == S_RUN) ? sy_r : {1'b0, cur_r.y};
  assign lin_addr = MW'(y_sel * cfg.w) + MW'(x_sel);
  assign dep_addr = AW'(lin_addr);
  assign dep_we   = (state_r == S_WDEP);

  always_ff @(posedge clk) begin
    if (dep_we) dep_mem[dep_addr] <= cur_r.depth;
    dep_rd_r <= dep_mem[dep_addr];
  end

  assign ofs_wr_idx = IW'(head.idx);
  assign ofs_rd_idx = iss_r[IW-1:0];

  always_ff @(posedge clk) begin
    if (ofs_we) begin
      ofs_x_mem[ofs_wr_idx] <= head.dx;
      ofs_y_mem[ofs_wr_idx] <= head.dy;
    end
    ofs_x_rd_r <= ofs_x_mem[ofs_rd_idx];
    ofs_y_rd_r <= ofs_y_mem[ofs_rd_idx];
  end

  assign occ = (cen_r > dep_rd_r) && ((cen_r - dep_rd_r) < cfg.radius);

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    cen_nxt       = cen_r;
    first_nxt     = 1'b0;
    iss_nxt       = iss_r;
    res_nxt       = res_r;
    cnt_nxt       = cnt_r;
    v1_nxt        = 1'b0;
    v2_nxt        = 1'b0;
    v3_nxt        = 1'b0;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_ao_nxt    = out_ao_r;
    out_cnt_nxt   = out_cnt_r;
    q_pop         = 1'b0;
    ofs_we        = 1'b0;
    div_start     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cur_nxt = head;
          case (head.op)
            OP_WR_OFS: ofs_we = 1'b1;
            OP_WR_DEP: state_nxt = S_WDEP;
            OP_QUERY:  state_nxt = S_CEN;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_WDEP: state_nxt = S_IDLE;
      S_CEN: begin
        iss_nxt   = '0;
        res_nxt   = '0;
        cnt_nxt   = '0;
        first_nxt = 1'b1;
        state_nxt = S_RUN;
      end
      S_RUN: begin
        if (first_r) cen_nxt = dep_rd_r;
        if (iss_r < cfg.n) begin
          v1_nxt  = 1'b1;
          iss_nxt = iss_r + 1'b1;
        end
        v2_nxt = v1_r;
        sx_nxt = clamp_off(cur_r.x, $signed(ofs_x_rd_r), cfg.w);
        sy_nxt = clamp_off(cur_r.y, $signed(ofs_y_rd_r), cfg.h);
        v3_nxt = v2_r;
        if (v3_r) begin
          res_nxt = res_r + 1'b1;
          if (occ) cnt_nxt = cnt_r + 1'b1;
        end
        if (res_r == cfg.n) begin
          v1_nxt    = 1'b0;
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_fin) state_nxt = S_PUT;
      end
      S_PUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_ao_nxt    = div_quo;
          out_cnt_nxt   = OCC_W'(cnt_r);
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      first_r     <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      first_r     <= first_nxt;
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      v3_r        <= v3_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r     <= cur_nxt;
    cen_r     <= cen_nxt;
    iss_r     <= iss_nxt;
    res_r     <= res_nxt;
    cnt_r     <= cnt_nxt;
    sx_r      <= sx_nxt;
    sy_r      <= sy_nxt;
    out_ao_r  <= out_ao_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  dao_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (cfg.n - cnt_r),
    .den   (cfg.n),
    .fin   (div_fin),
    .quo   (div_quo)
  );

  assign out_valid          = out_valid_r;
  assign out_ao_level       = out_ao_r;
  assign out_occluded_count = out_cnt_r;

endmodule

// ===== src/depth_ambient_occlusion.sv =====
// Depth ambient occlusion: from acceptance to its result beat, a query runs a
// centre read, one offset and one depth read per sample on the single-port
// depth frame, a sample pipeline and then a 16-step divider; an offset write
// is done as it leaves the queue and a depth write goes through the write state.
// Reset clears control state and restores the configuration defaults; the
// depth frame and offset tables are not cleared and hold nothing until written.
module depth_ambient_occlusion #(
  parameter int MAX_SAMPLES_P = 64,
  parameter int MAX_WIDTH     = 256,
  parameter int MAX_HEIGHT    = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [dao_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dao_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_func,
  input  logic [5:0]                      in_entry_index,
  input  logic signed [7:0]               in_offset_dx,
  input  logic signed [7:0]               in_offset_dy,
  input  logic [7:0]                      in_pos_x,
  input  logic [7:0]                      in_pos_y,
  input  logic [15:0]                     in_depth_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [15:0]                     out_ao_level,
  output logic [6:0]                      out_occluded_count
);
  import dao_pkg::*;

  // Configuration registers: the user must write them only while the block is idle; the block does not enforce it.
  logic [6:0]  sample_count_r;
  logic [15:0] radius_r;
  logic [8:0]  frame_width_r;
  logic [8:0]  frame_height_r;
  cfg_t        cfg;

  item_t       push_item, head;
  logic        q_push, q_pop, q_empty, q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= 7'd16;
      radius_r       <= 16'd32768;
      frame_width_r  <= 9'd256;
      frame_height_r <= 9'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SAMPLE_COUNT: sample_count_r <= cfg_data[6:0];
        CFG_RADIUS:       radius_r       <= cfg_data;
        CFG_WIDTH:        frame_width_r  <= cfg_data[8:0];
        CFG_HEIGHT:       frame_height_r <= cfg_data[8:0];
        default:          sample_count_r <= sample_count_r;
      endcase
    end
  end

  // Range limiting. A zero frame size acts as one, and anything above the
  // built-in maximum acts as that maximum. The sample count saturates at the
  // table depth; zero samples falls out of the divider as full exposure.
  always_comb begin
    cfg.radius = radius_r;
    if (32'(sample_count_r) > MAX_SAMPLES_P) cfg.n = NCNT_W'(MAX_SAMPLES_P);
    else cfg.n = NCNT_W'(sample_count_r);
    if (frame_width_r == '0) cfg.w = DIM_W'(1);
    else if (32'(frame_width_r) > MAX_WIDTH) cfg.w = DIM_W'(MAX_WIDTH);
    else cfg.w = DIM_W'(frame_width_r);
    if (frame_height_r == '0) cfg.h = DIM_W'(1);
    else if (32'(frame_height_r) > MAX_HEIGHT) cfg.h = DIM_W'(MAX_HEIGHT);
    else cfg.h = DIM_W'(frame_height_r);
  end

  // The front end takes a beat whenever the queue has room, so writes and
  // further queries keep flowing while a result beat waits on out_stall.
  dao_front #(
    .MAX_SAMPLES_P (MAX_SAMPLES_P)
  ) u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_entry_index (in_entry_index),
    .in_offset_dx   (in_offset_dx),
    .in_offset_dy   (in_offset_dy),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_depth_value (in_depth_value),
    .cfg            (cfg),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (push_item)
  );

  dao_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // The back end runs one queued beat at a time and owns both memories.
  dao_back #(
    .MAX_SAMPLES_P (MAX_SAMPLES_P),
    .MAX_WIDTH     (MAX_WIDTH),
    .MAX_HEIGHT    (MAX_HEIGHT)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .head               (head),
    .q_empty            (q_empty),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_ao_level       (out_ao_level),
    .out_occluded_count (out_occluded_count)
  );

endmodule

// ===== bench/dao_checker.sv =====
// Result checker for the depth ambient occlusion block: watches the register,
// input and result ports, predicts each query result and compares it.
// Depends on dao_pkg for port widths, function codes and register indexes.
module dao_checker
  import dao_pkg::*;
#(
  parameter int MAX_SAMPLES_P = 64,
  parameter int MAX_WIDTH     = 256,
  parameter int MAX_HEIGHT    = 256
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [1:0]              in_func,
  input  logic [5:0]              in_entry_index,
  input  logic signed [7:0]       in_offset_dx,
  input  logic signed [7:0]       in_offset_dy,
  input  logic [7:0]              in_pos_x,
  input  logic [7:0]              in_pos_y,
  input  logic [15:0]             in_depth_value,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [15:0]             out_ao_level,
  input  logic [6:0]              out_occluded_count,
  output int                      fail_count,
  output int                      pending_results,
  output int                      results_seen
);

  typedef struct packed {
    logic [15:0] ao;
    logic [6:0]  occ;
  } occl_t;

  logic [15:0]       depth_frame [0:65535];
  logic signed [7:0] kernel_dx [0:MAX_SAMPLES_P-1];
  logic signed [7:0] kernel_dy [0:MAX_SAMPLES_P-1];

  logic [6:0]  reg_samples;
  logic [15:0] reg_radius;
  logic [8:0]  reg_width;
  logic [8:0]  reg_height;

  occl_t ao_expect_q[$];
  int    mismatches;
  int    results_got;

  initial begin
    fail_count      = 0;
    pending_results = 0;
    results_seen    = 0;
    mismatches      = 0;
    results_got     = 0;
  end

  // A width or height of zero acts as one; anything above the maximum is cut.
  function automatic int eff_dim(logic [8:0] v, int maxv);
    if (v == 0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic int clamp_coord(int p, int size);
    if (p < 0) return 0;
    if (p >= size) return size - 1;
    return p;
  endfunction

  function automatic occl_t occlusion_of(int px, int py);
    occl_t  r;
    int     w, h, n, cx, cy, sx, sy, centre, diff, hits;
    longint level;
    w = eff_dim(reg_width, MAX_WIDTH);
    h = eff_dim(reg_height, MAX_HEIGHT);
    n = (int'(reg_samples) > MAX_SAMPLES_P) ? MAX_SAMPLES_P : int'(reg_samples);
    cx = clamp_coord(px, w);
    cy = clamp_coord(py, h);
    centre = int'(depth_frame[cy * w + cx]);
    hits = 0;
    for (int i = 0; i < n; i++) begin
      sx = clamp_coord(cx + kernel_dx[i], w);
      sy = clamp_coord(cy + kernel_dy[i], h);
      diff = centre - int'(depth_frame[sy * w + sx]);
      if (diff > 0 && diff < int'(reg_radius)) hits++;
    end
    if (n == 0) begin
      level = 65535;
    end else begin
      level = (longint'(n - hits) * 65536) / n;
      if (level > 65535) level = 65535;
    end
    r.ao  = level[15:0];
    r.occ = hits[6:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, occl_t want, occl_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] %s: expected ao_level %0d occluded_count %0d, got %0d %0d",
               $realtime, what, want.ao, want.occ, got.ao, got.occ);
  endtask

  always @(posedge clk) begin : track
    occl_t got, want;
    if (!rst_n) begin
      reg_samples = 7'd16;
      reg_radius  = 16'd32768;
      reg_width   = 9'd256;
      reg_height  = 9'd256;
      ao_expect_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SAMPLE_COUNT: reg_samples = cfg_data[6:0];
          CFG_RADIUS:       reg_radius  = cfg_data[15:0];
          CFG_WIDTH:        reg_width   = cfg_data[8:0];
          CFG_HEIGHT:       reg_height  = cfg_data[8:0];
          default: ;
        endcase
      end
      // Results are matched before new queries are queued: a beat leaving
      // the block in this cycle can never belong to a query entering it.
      if (out_valid && !out_stall) begin
        got.ao  = out_ao_level;
        got.occ = out_occluded_count;
        results_got++;
        if (ao_expect_q.size() == 0) begin
          want = '0;
          report_mismatch("result with no query waiting", want, got);
        end else begin
          want = ao_expect_q.pop_front();
          if (got !== want) report_mismatch("result mismatch", want, got);
        end
      end
      if (in_valid && !in_stall) begin
        case (in_func)
          FUNC_WR_OFS: begin
            kernel_dx[in_entry_index] = in_offset_dx;
            kernel_dy[in_entry_index] = in_offset_dy;
          end
          FUNC_WR_DEP: begin
            if (int'(in_pos_x) < eff_dim(reg_width, MAX_WIDTH) &&
                int'(in_pos_y) < eff_dim(reg_height, MAX_HEIGHT))
              depth_frame[int'(in_pos_y) * eff_dim(reg_width, MAX_WIDTH) + int'(in_pos_x)]
                = in_depth_value;
          end
          FUNC_QUERY: ao_expect_q.push_back(occlusion_of(in_pos_x, in_pos_y));
          default: ;
        endcase
      end
    end
    pending_results <= ao_expect_q.size();
    fail_count      <= mismatches;
    results_seen    <= results_got;
  end

endmodule

// ===== bench/tb_top.sv =====
// Top level of the depth ambient occlusion testbench: clock, reset, register
// writes, input stimulus, result back-pressure, watchdog and final verdict.
// Depends on dao_pkg, depth_ambient_occlusion and dao_checker.
module tb_top;
  import dao_pkg::*;

  // Function code that the block must ignore; the package has no name for it.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam int MAX_SAMPLES    = 64;
  localparam int MAX_DIM        = 256;
  localparam int ITEM_GOAL      = 650;
  localparam int NUM_SETTINGS   = 12;
  localparam int MIN_QUERIES    = 3;
  // Up to four writes may sit queued in the block, so this covers any write still
  // in flight after the last result.
  localparam int SETTLE_CYCLES  = 40;
  // The limit leaves a wide margin over a full-size query plus the longest stall
  // on either side.
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct {
    logic [15:0] n;
    logic [15:0] radius;
    logic [15:0] w;
    logic [15:0] h;
  } setting_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = CFG_SAMPLE_COUNT;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [1:0]              in_func = FUNC_WR_OFS;
  logic [5:0]              in_entry_index = '0;
  logic signed [7:0]       in_offset_dx = '0;
  logic signed [7:0]       in_offset_dy = '0;
  logic [7:0]              in_pos_x = '0;
  logic [7:0]              in_pos_y = '0;
  logic [15:0]             in_depth_value = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [15:0]             out_ao_level;
  logic [6:0]              out_occluded_count;

  int fail_count;
  int pending_results;
  int results_seen;

  // Stimulus-side view of the block: which depth addresses hold data, what
  // the kernel table holds and the effective register values. It is used only
  // to steer stimulus so that no query ever reads an unwritten location.
  bit                depth_written [0:65535];
  logic signed [7:0] kern_dx [0:MAX_SAMPLES-1];
  logic signed [7:0] kern_dy [0:MAX_SAMPLES-1];
  int cur_n, cur_radius, cur_w, cur_h;

  int depth_base, depth_spread;
  int tx_mode, rx_mode;
  int stim_items, queries_sent, settings_run;
  int idle_cycles;
  int rx_wait;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  depth_ambient_occlusion uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_entry_index     (in_entry_index),
    .in_offset_dx       (in_offset_dx),
    .in_offset_dy       (in_offset_dy),
    .in_pos_x           (in_pos_x),
    .in_pos_y           (in_pos_y),
    .in_depth_value     (in_depth_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_ao_level       (out_ao_level),
    .out_occluded_count (out_occluded_count)
  );

  dao_checker ao_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_entry_index     (in_entry_index),
    .in_offset_dx       (in_offset_dx),
    .in_offset_dy       (in_offset_dy),
    .in_pos_x           (in_pos_x),
    .in_pos_y           (in_pos_y),
    .in_depth_value     (in_depth_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_ao_level       (out_ao_level),
    .out_occluded_count (out_occluded_count),
    .fail_count         (fail_count),
    .pending_results    (pending_results),
    .results_seen       (results_seen)
  );

  // Idle profiles: mode 0 never waits, mode 1 waits about half the time and
  // mode 2 always draws a wait. Each draw lies between 0 and 16 inclusive.
  function automatic int draw_wait(int mode);
    if (mode == 0) return 0;
    if (mode == 1 && $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  function automatic int clamp_coord(int p, int size);
    if (p < 0) return 0;
    if (p >= size) return size - 1;
    return p;
  endfunction

  function automatic int eff_dim(logic [8:0] v);
    if (v == 0) return 1;
    if (int'(v) > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  // Depths cluster around a per-setting base so that differences land both
  // inside and outside the radius, with the exact boundaries drawn on purpose.
  function automatic logic [15:0] pick_depth();
    int v;
    case ($urandom_range(0, 9))
      0:       v = $urandom_range(0, 65535);
      1:       v = depth_base;
      2:       v = depth_base - cur_radius;
      3:       v = depth_base - cur_radius + 1;
      4:       v = depth_base + cur_radius;
      default: v = depth_base + int'($urandom_range(0, 2 * depth_spread)) - depth_spread;
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  // Small offsets make neighbouring samples share pixels; full-range ones
  // exercise clamping at the frame edges.
  function automatic logic signed [7:0] draw_offset();
    if ($urandom_range(0, 1) == 0) return 8'(int'($urandom_range(0, 8)) - 4);
    return 8'($urandom);
  endfunction

  // Presents one beat and holds it until the block takes it. The valid line
  // is only lowered when a gap is drawn, so back-to-back beats keep it high.
  task automatic send_beat(logic [1:0] f, logic [5:0] idx, logic signed [7:0] dx,
                           logic signed [7:0] dy, logic [7:0] x, logic [7:0] y,
                           logic [15:0] d);
    int gap;
    gap = draw_wait(tx_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= f;
    in_entry_index <= idx;
    in_offset_dx   <= dx;
    in_offset_dy   <= dy;
    in_pos_x       <= x;
    in_pos_y       <= y;
    in_depth_value <= d;
    do @(posedge clk); while (in_stall);
  endtask

  // Fields that an operation does not use still carry random bits.
  task automatic write_offset(int e, logic signed [7:0] dx, logic signed [7:0] dy);
    send_beat(FUNC_WR_OFS, e[5:0], dx, dy, 8'($urandom), 8'($urandom), 16'($urandom));
    kern_dx[e] = dx;
    kern_dy[e] = dy;
    stim_items++;
  endtask

  task automatic write_depth(int x, int y, logic [15:0] d);
    send_beat(FUNC_WR_DEP, 6'($urandom), 8'($urandom), 8'($urandom), x[7:0], y[7:0], d);
    if (x < cur_w && y < cur_h) depth_written[y * cur_w + x] = 1'b1;
    stim_items++;
  endtask

  task automatic noise_beat();
    send_beat(FUNC_UNUSED, 6'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom), 16'($urandom));
  endtask

  // Before a query goes out, every pixel that it will read (the clamped
  // centre and each clamped sample) gets a depth if it has none yet.
  task automatic query(int x, int y);
    int cx, cy, sx, sy;
    cx = clamp_coord(x, cur_w);
    cy = clamp_coord(y, cur_h);
    for (int i = -1; i < cur_n; i++) begin
      if (i < 0) begin
        sx = cx;
        sy = cy;
      end else begin
        sx = clamp_coord(cx + kern_dx[i], cur_w);
        sy = clamp_coord(cy + kern_dy[i], cur_h);
      end
      if (!depth_written[sy * cur_w + sx]) write_depth(sx, sy, pick_depth());
    end
    send_beat(FUNC_QUERY, 6'($urandom), 8'($urandom), 8'($urandom), x[7:0], y[7:0],
              16'($urandom));
    stim_items++;
    queries_sent++;
  endtask

  // Stops sending and waits until every query has produced its result beat.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  // Registers are only written with the block idle: all results in and any
  // trailing writes given time to retire.
  task automatic write_config(setting_t s);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SAMPLE_COUNT;
    cfg_data  <= s.n;
    @(posedge clk);
    cfg_index <= CFG_RADIUS;
    cfg_data  <= s.radius;
    @(posedge clk);
    cfg_index <= CFG_WIDTH;
    cfg_data  <= s.w;
    @(posedge clk);
    cfg_index <= CFG_HEIGHT;
    cfg_data  <= s.h;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_n      = (int'(s.n[6:0]) > MAX_SAMPLES) ? MAX_SAMPLES : int'(s.n[6:0]);
    cur_radius = int'(s.radius);
    cur_w      = eff_dim(s.w[8:0]);
    cur_h      = eff_dim(s.h[8:0]);
  endtask

  // Random traffic under one register setting: mostly queries, with depth
  // rewrites (some outside the frame), kernel rewrites and ignored codes.
  task automatic run_setting(int budget);
    int start_items, start_queries, r, x, y;
    start_items   = stim_items;
    start_queries = queries_sent;
    while (stim_items - start_items < budget || queries_sent - start_queries < MIN_QUERIES) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        if ($urandom_range(0, 4) == 0) begin
          x = $urandom_range(0, 255);
          y = $urandom_range(0, 255);
        end else begin
          x = $urandom_range(0, cur_w - 1);
          y = $urandom_range(0, cur_h - 1);
        end
        query(x, y);
      end else if (r < 70) begin
        write_depth($urandom_range(0, cur_w - 1), $urandom_range(0, cur_h - 1), pick_depth());
      end else if (r < 80) begin
        write_depth($urandom_range(0, 255), $urandom_range(0, 255), pick_depth());
      end else if (r < 92) begin
        write_offset($urandom_range(0, MAX_SAMPLES - 1), draw_offset(), draw_offset());
      end else begin
        noise_beat();
      end
    end
  endtask

  // Result side back-pressure: after each accepted result beat a new stall
  // length is drawn, and the stall then counts down whether or not the next
  // result is already waiting, so it lands on every phase of a query.
  always @(posedge clk) begin : rx_idle
    int hold;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait   <= 0;
    end else if (out_valid && !out_stall) begin
      hold = draw_wait(rx_mode);
      rx_wait   <= hold;
      out_stall <= (hold != 0);
    end else if (rx_wait > 0) begin
      rx_wait   <= rx_wait - 1;
      out_stall <= (rx_wait > 1);
    end
  end

  // Watchdog: any handshake or register write counts as progress.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d cycles without progress", idle_cycles);
      $display("depth_ambient_occlusion verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    setting_t settings [NUM_SETTINGS];
    setting_t s;
    tx_mode      = 0;
    rx_mode      = 0;
    stim_items   = 0;
    queries_sent = 0;
    settings_run = 0;
    idle_cycles  = 0;
    depth_base   = 40000;
    depth_spread = 8000;
    // Fixed settings cover the register extremes: one sample and the full
    // kernel, a zero and a full radius, a single pixel and the whole frame,
    // no samples at all, and out-of-range counts and sizes that must be
    // limited (including data with the unused upper bits set).
    settings[0] = '{16'd16,    16'd32768, 16'd16,    16'd16};
    settings[1] = '{16'd64,    16'd65535, 16'd256,   16'd256};
    settings[2] = '{16'd1,     16'd0,     16'd1,     16'd1};
    settings[3] = '{16'd0,     16'd20000, 16'd8,     16'd8};
    settings[4] = '{16'd100,   16'd1000,  16'd0,     16'd300};
    settings[5] = '{16'd8,     16'd4096,  16'd256,   16'd3};
    settings[6] = '{16'd32,    16'd16384, 16'd5,     16'd200};
    settings[7] = '{16'hFFC3,  16'hFFFF,  16'hFF08,  16'hFE00};
    for (int i = 8; i < NUM_SETTINGS; i++)
      settings[i] = '{16'($urandom_range(1, 64)), 16'($urandom_range(0, 65535)),
                      16'($urandom_range(1, 32)), 16'($urandom_range(1, 32))};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part on a 2x2 frame with four samples: kernel entries at the
    // ends of the table and of the offset range, depths at both extremes,
    // a depth write outside the frame, an ignored function code, a query
    // outside the frame that must clamp to the corner, and a zero-depth
    // centre that sees no occlusion and so saturates the exposure.
    write_config('{16'd4, 16'd32768, 16'd2, 16'd2});
    write_offset(0, -8'sd128, 8'sd127);
    write_offset(1, 8'sd127, -8'sd128);
    write_offset(2, 8'sd0, 8'sd0);
    write_offset(3, 8'sd1, -8'sd1);
    write_offset(63, -8'sd1, 8'sd1);
    write_depth(0, 0, 16'hFFFF);
    write_depth(1, 0, 16'h0000);
    write_depth(0, 1, 16'd40000);
    write_depth(1, 1, 16'd30000);
    write_depth(255, 255, 16'd12345);
    noise_beat();
    query(0, 0);
    query(255, 255);
    query(1, 0);
    query(0, 1);

    // Fill the whole kernel table once so every sample count reads only
    // entries that hold data.
    for (int e = 0; e < MAX_SAMPLES; e++) write_offset(e, draw_offset(), draw_offset());

    for (int i = 0; i < NUM_SETTINGS; i++) begin
      s = settings[i];
      write_config(s);
      depth_base   = $urandom_range(0, 65535);
      depth_spread = $urandom_range(16, 20000);
      // The first setting runs with no idling on either side.
      tx_mode = (i == 0) ? 0 : $urandom_range(0, 2);
      rx_mode = (i == 0) ? 0 : $urandom_range(0, 2);
      run_setting(ITEM_GOAL / NUM_SETTINGS);
      settings_run++;
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d register settings, %0d stimulus beats and %0d queries;",
             settings_run + 1, stim_items, queries_sent);
    $display("%0d result beats were compared, %0d of them wrong.", results_seen, fail_count);
    if (fail_count == 0 && pending_results == 0) begin
      $display("depth_ambient_occlusion verification clean");
    end else begin
      $display("depth_ambient_occlusion verification failed");
    end
    $finish;
  end

endmodule
